### rtl/emcp_pkg.sv
`default_nettype none

package emcp_pkg;

    // operation codes of the input channel
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    // curve modes
    localparam logic [1:0] CURVE_SMOOTH = 2'd0;
    localparam logic [1:0] CURVE_CUBIC  = 2'd1;
    localparam logic [1:0] CURVE_SCALE  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_START_LON   = 3'd0;
    localparam logic [2:0] REG_START_LAT   = 3'd1;
    localparam logic [2:0] REG_START_ZOOM  = 3'd2;
    localparam logic [2:0] REG_TARGET_LON  = 3'd3;
    localparam logic [2:0] REG_TARGET_LAT  = 3'd4;
    localparam logic [2:0] REG_TARGET_ZOOM = 3'd5;
    localparam logic [2:0] REG_DURATION    = 3'd6;
    localparam logic [2:0] REG_CURVE_MODE  = 3'd7;

    // angles in units of 2^-20 degree
    localparam logic signed [31:0] DEG_180 = 32'sd188743680;
    localparam logic signed [31:0] DEG_360 = 32'sd377487360;
    localparam logic signed [31:0] DEG_540 = 32'sd566231040;
    localparam logic signed [31:0] LAT_MAX = 32'sd89128960;
    localparam logic signed [31:0] LAT_MIN = -32'sd89128960;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // y is x + 180 degrees; fold into [-180, 180) with one correction
    function automatic logic signed [31:0] wrap_fix(input logic signed [31:0] y);
        logic signed [31:0] r;
        if (y[31]) begin
            r = y + DEG_180;
        end else if (y >= DEG_360) begin
            r = y - DEG_540;
        end else begin
            r = y - DEG_180;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_lat(input logic signed [31:0] x);
        logic signed [31:0] r;
        if (x > LAT_MAX) begin
            r = LAT_MAX;
        end else if (x < LAT_MIN) begin
            r = LAT_MIN;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/eased_map_camera_interpolator_top.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_valid / s_ready    s_operation[1:0], s_now_us[47:0]
// m_*       out  m_valid / m_ready    m_updated, m_out_lon, m_out_lat, m_out_zoom, m_finished
// cfg_*     in   cfg_wr_en            cfg_addr[2:0], cfg_wdata[31:0]
//
// After reset a bit-serial square root fills the root ROM with 16 roots while s_ready is low.
// Start, cancel and idle items go from the dispatch state straight to the output state;
// a finishing tick passes the progress check, the final-value state and the longitude fix.
// An easing tick runs the 49-step shared divider (not when the tick is earlier than the
// start); scale-normalised mode adds two 2^-y evaluations over the shared multiplier
// and a second divide.
// One item is in work at a time; the output register lets the next item in while a
// result waits for m_ready.

`default_nettype none

module eased_map_camera_interpolator_top
    import emcp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [47:0]        s_now_us,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_updated,
    output logic signed [28:0]      m_out_lon,
    output logic signed [27:0]      m_out_lat,
    output logic [20:0]             m_out_zoom,
    output logic                    m_finished,

    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata
);

    localparam logic [4:0] ST_INIT_LOAD = 5'd0;
    localparam logic [4:0] ST_INIT_STEP = 5'd1;
    localparam logic [4:0] ST_IDLE      = 5'd2;
    localparam logic [4:0] ST_DISPATCH  = 5'd3;
    localparam logic [4:0] ST_PROG      = 5'd4;
    localparam logic [4:0] ST_DIV       = 5'd5;
    localparam logic [4:0] ST_DIV_DONE  = 5'd6;
    localparam logic [4:0] ST_PCHK      = 5'd7;
    localparam logic [4:0] ST_EASE1     = 5'd8;
    localparam logic [4:0] ST_EASE2     = 5'd9;
    localparam logic [4:0] ST_EASE3     = 5'd10;
    localparam logic [4:0] ST_SN_START  = 5'd11;
    localparam logic [4:0] ST_EXP_MUL   = 5'd12;
    localparam logic [4:0] ST_EXP_ACC   = 5'd13;
    localparam logic [4:0] ST_EXP_SHIFT = 5'd14;
    localparam logic [4:0] ST_SN_Y      = 5'd15;
    localparam logic [4:0] ST_SN_Y2     = 5'd16;
    localparam logic [4:0] ST_SN_ND     = 5'd17;
    localparam logic [4:0] ST_DELTA1    = 5'd18;
    localparam logic [4:0] ST_DELTA2    = 5'd19;
    localparam logic [4:0] ST_MQ_SETUP  = 5'd20;
    localparam logic [4:0] ST_MQ_ABS    = 5'd21;
    localparam logic [4:0] ST_MQ_MUL    = 5'd22;
    localparam logic [4:0] ST_MQ_RND    = 5'd23;
    localparam logic [4:0] ST_MQ_APPLY  = 5'd24;
    localparam logic [4:0] ST_LON_FIX   = 5'd25;
    localparam logic [4:0] ST_LAT_CLAMP = 5'd26;
    localparam logic [4:0] ST_FIN       = 5'd27;
    localparam logic [4:0] ST_OUT       = 5'd28;

    localparam logic [1:0] SEL_LON  = 2'd0;
    localparam logic [1:0] SEL_LAT  = 2'd1;
    localparam logic [1:0] SEL_ZOOM = 2'd2;

    // configuration registers
    logic signed [28:0] slon_reg, tlon_reg;
    logic signed [27:0] slat_reg, tlat_reg;
    logic [20:0]        szoom_reg, tzoom_reg;
    logic [31:0]        dur_reg;
    logic [1:0]         mode_reg;

    // control
    logic [4:0]  state_reg, state_next;
    logic        running_reg, running_next;
    logic [47:0] begin_reg, begin_next;
    logic [1:0]  op_reg, op_next;
    logic [47:0] now_reg, now_next;

    // root ROM fill
    logic [31:0] krom_mem [0:15];
    logic [31:0] krom_rd_reg;
    logic [3:0]  kidx_reg, kidx_next;
    logic [63:0] sq_x_reg, sq_x_next;
    logic [33:0] sq_rem_reg, sq_rem_next;
    logic [31:0] sq_root_reg, sq_root_next;
    logic [4:0]  sq_cnt_reg, sq_cnt_next;
    logic [35:0] sq_sh, sq_trial, sq_sub;

    // shared divider
    logic [48:0] el_reg, el_next;
    logic [32:0] div_r_reg, div_r_next;
    logic [48:0] div_q_reg, div_q_next;
    logic [32:0] div_v_reg, div_v_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic        div_for_p_reg, div_for_p_next;
    logic [33:0] div_sh, div_sub;

    // shared multiplier
    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [65:0] prod_reg, rnd32, rnd16;

    logic [16:0] p_reg, p_next;
    logic [16:0] e_reg, e_next;
    logic [16:0] c_reg, c_next;
    logic [16:0] inv, e_calc;
    logic [17:0] ss_fac;
    logic        cubic;

    // scale-normalised path
    logic [21:0] dz_calc, dz_neg_val;
    logic [20:0] a_calc;
    logic [20:0] a_reg, a_next;
    logic        dzneg_reg, dzneg_next;
    logic [32:0] acc_reg, acc_next;
    logic [3:0]  k_reg, k_next;
    logic [4:0]  yint_reg, yint_next;
    logic [15:0] yfrac_reg, yfrac_next;
    logic        exp_second_reg, exp_second_next;
    logic [32:0] ea_reg, ea_next, eb_reg, eb_next, eres;
    logic [33:0] num_calc, den_calc;

    // interpolation
    logic signed [31:0] dx_reg, dx_next, delta_reg, delta_next;
    logic [1:0]         which_reg, which_next;
    logic signed [31:0] opv_reg, opv_next, opv_neg;
    logic [16:0]        q_reg, q_next;
    logic               neg_reg, neg_next;
    logic [31:0]        mag_reg, mag_next;
    logic signed [31:0] r_reg, r_next, mq_term;
    logic signed [31:0] sum_reg, sum_next, zsum, lon_fixed, lat_fixed, tlat_c;

    // result staging and output register
    logic               res_upd_reg, res_upd_next, res_fin_reg, res_fin_next;
    logic signed [28:0] res_lon_reg, res_lon_next;
    logic signed [27:0] res_lat_reg, res_lat_next;
    logic [20:0]        res_zoom_reg, res_zoom_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_upd_reg, m_upd_next, m_fin_reg, m_fin_next;
    logic signed [28:0] m_lon_reg, m_lon_next;
    logic signed [27:0] m_lat_reg, m_lat_next;
    logic [20:0]        m_zoom_reg, m_zoom_next;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_updated  = m_upd_reg;
    assign m_out_lon  = m_lon_reg;
    assign m_out_lat  = m_lat_reg;
    assign m_out_zoom = m_zoom_reg;
    assign m_finished = m_fin_reg;

    // datapath helpers
    assign sq_sh    = {sq_rem_reg, sq_x_reg[63:62]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_sub   = sq_sh - sq_trial;

    assign div_sh  = {div_r_reg, div_q_reg[48]};
    assign div_sub = div_sh - {1'b0, div_v_reg};

    assign rnd32 = prod_reg + 66'h0_8000_0000;
    assign rnd16 = prod_reg + 66'd32768;

    assign cubic  = (mode_reg == CURVE_CUBIC);
    assign inv    = ONE_Q16 - p_reg;
    assign ss_fac = 18'd196608 - {p_reg, 1'b0};
    assign e_calc = cubic ? (ONE_Q16 - rnd32[48:32]) : rnd32[48:32];

    assign dz_calc    = {1'b0, tzoom_reg} - {1'b0, szoom_reg};
    assign dz_neg_val = 22'd0 - dz_calc;
    assign a_calc     = dz_calc[21] ? dz_neg_val[20:0] : dz_calc[20:0];
    assign eres       = acc_reg >> yint_reg;
    assign num_calc   = dzneg_reg ? ({1'b0, eb_reg} - {1'b0, ea_reg})
                                  : (34'h1_0000_0000 - {1'b0, eb_reg});
    assign den_calc   = 34'h1_0000_0000 - {1'b0, ea_reg};

    assign opv_neg   = 32'sd0 - opv_reg;
    assign mq_term   = neg_reg ? (32'sd0 - r_reg) : r_reg;
    assign zsum      = 32'($signed({1'b0, szoom_reg})) + mq_term;
    assign lon_fixed = wrap_fix(sum_reg);
    assign lat_fixed = clamp_lat(sum_reg);
    assign tlat_c    = clamp_lat(32'(tlat_reg));

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        state_next      = state_reg;
        running_next    = running_reg;
        begin_next      = begin_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        kidx_next       = kidx_reg;
        sq_x_next       = sq_x_reg;
        sq_rem_next     = sq_rem_reg;
        sq_root_next    = sq_root_reg;
        sq_cnt_next     = sq_cnt_reg;
        el_next         = el_reg;
        div_r_next      = div_r_reg;
        div_q_next      = div_q_reg;
        div_v_next      = div_v_reg;
        div_cnt_next    = div_cnt_reg;
        div_for_p_next  = div_for_p_reg;
        p_next          = p_reg;
        e_next          = e_reg;
        c_next          = c_reg;
        a_next          = a_reg;
        dzneg_next      = dzneg_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        yint_next       = yint_reg;
        yfrac_next      = yfrac_reg;
        exp_second_next = exp_second_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        dx_next         = dx_reg;
        delta_next      = delta_reg;
        which_next      = which_reg;
        opv_next        = opv_reg;
        q_next          = q_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        r_next          = r_reg;
        sum_next        = sum_reg;
        res_upd_next    = res_upd_reg;
        res_fin_next    = res_fin_reg;
        res_lon_next    = res_lon_reg;
        res_lat_next    = res_lat_reg;
        res_zoom_next   = res_zoom_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_upd_next      = m_upd_reg;
        m_fin_next      = m_fin_reg;
        m_lon_next      = m_lon_reg;
        m_lat_next      = m_lat_reg;
        m_zoom_next     = m_zoom_reg;
        mul_a           = '0;
        mul_b           = '0;

        unique case (state_reg)
            ST_INIT_LOAD: begin
                sq_x_next    = {(kidx_reg == 4'd0) ? 32'h8000_0000 : sq_root_reg, 32'd0};
                sq_rem_next  = '0;
                sq_root_next = '0;
                sq_cnt_next  = '0;
                state_next   = ST_INIT_STEP;
            end
            ST_INIT_STEP: begin
                sq_x_next = {sq_x_reg[61:0], 2'b00};
                if (sq_sh >= sq_trial) begin
                    sq_rem_next  = sq_sub[33:0];
                    sq_root_next = {sq_root_reg[30:0], 1'b1};
                end else begin
                    sq_rem_next  = sq_sh[33:0];
                    sq_root_next = {sq_root_reg[30:0], 1'b0};
                end
                sq_cnt_next = sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'd31) begin
                    kidx_next  = kidx_reg + 4'd1;
                    state_next = (kidx_reg == 4'd15) ? ST_IDLE : ST_INIT_LOAD;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    now_next   = s_now_us;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                res_upd_next  = 1'b0;
                res_fin_next  = 1'b0;
                res_lon_next  = '0;
                res_lat_next  = '0;
                res_zoom_next = '0;
                el_next       = {1'b0, now_reg} - {1'b0, begin_reg};
                state_next    = ST_OUT;
                case (op_reg)
                    OP_START: begin
                        running_next = 1'b1;
                        begin_next   = now_reg;
                    end
                    OP_CANCEL: begin
                        running_next = 1'b0;
                    end
                    OP_TICK: begin
                        if (running_reg) begin
                            state_next = ST_PROG;
                        end
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_PROG: begin
                // zero duration or elapsed past the end: full progress
                if (dur_reg == 32'd0) begin
                    p_next     = ONE_Q16;
                    state_next = ST_PCHK;
                end else if (el_reg[48]) begin
                    p_next     = '0;
                    state_next = ST_PCHK;
                end else if (el_reg[47:0] >= {16'd0, dur_reg}) begin
                    p_next     = ONE_Q16;
                    state_next = ST_PCHK;
                end else begin
                    div_r_next     = '0;
                    div_q_next     = {1'b0, el_reg[31:0], 16'd0};
                    div_v_next     = {1'b0, dur_reg};
                    div_cnt_next   = 6'd48;
                    div_for_p_next = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_sh >= {1'b0, div_v_reg}) begin
                    div_r_next = div_sub[32:0];
                    div_q_next = {div_q_reg[47:0], 1'b1};
                end else begin
                    div_r_next = div_sh[32:0];
                    div_q_next = {div_q_reg[47:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd0) begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                if (div_for_p_reg) begin
                    p_next     = div_q_reg[16:0];
                    state_next = ST_PCHK;
                end else begin
                    c_next     = (div_q_reg > 49'd65536) ? ONE_Q16 : div_q_reg[16:0];
                    state_next = ST_DELTA1;
                end
            end
            ST_PCHK: begin
                res_upd_next = 1'b1;
                res_fin_next = p_reg[16];
                state_next   = p_reg[16] ? ST_FIN : ST_EASE1;
            end
            ST_EASE1: begin
                mul_a      = 34'(cubic ? inv : p_reg);
                mul_b      = 32'(cubic ? inv : p_reg);
                state_next = ST_EASE2;
            end
            ST_EASE2: begin
                mul_a      = prod_reg[33:0];
                mul_b      = cubic ? 32'(inv) : 32'(ss_fac);
                state_next = ST_EASE3;
            end
            ST_EASE3: begin
                e_next = e_calc;
                if (mode_reg == CURVE_SCALE) begin
                    state_next = ST_SN_START;
                end else begin
                    c_next     = e_calc;
                    state_next = ST_DELTA1;
                end
            end
            ST_SN_START: begin
                if (dz_calc == 22'd0) begin
                    c_next     = e_reg;
                    state_next = ST_DELTA1;
                end else begin
                    a_next          = a_calc;
                    dzneg_next      = dz_calc[21];
                    acc_next        = 33'h1_0000_0000;
                    k_next          = '0;
                    yint_next       = a_calc[20:16];
                    yfrac_next      = a_calc[15:0];
                    exp_second_next = 1'b0;
                    state_next      = ST_EXP_MUL;
                end
            end
            ST_EXP_MUL: begin
                mul_a      = 34'(acc_reg);
                mul_b      = krom_rd_reg;
                state_next = ST_EXP_ACC;
            end
            ST_EXP_ACC: begin
                if (yfrac_reg[15]) begin
                    acc_next = rnd32[64:32];
                end
                yfrac_next = {yfrac_reg[14:0], 1'b0};
                k_next     = k_reg + 4'd1;
                state_next = (k_reg == 4'd15) ? ST_EXP_SHIFT : ST_EXP_MUL;
            end
            ST_EXP_SHIFT: begin
                if (exp_second_reg) begin
                    eb_next    = eres;
                    state_next = ST_SN_ND;
                end else begin
                    ea_next    = eres;
                    state_next = ST_SN_Y;
                end
            end
            ST_SN_Y: begin
                mul_a      = 34'(a_reg);
                mul_b      = 32'(dzneg_reg ? (ONE_Q16 - e_reg) : e_reg);
                state_next = ST_SN_Y2;
            end
            ST_SN_Y2: begin
                acc_next        = 33'h1_0000_0000;
                k_next          = '0;
                yint_next       = rnd16[36:32];
                yfrac_next      = rnd16[31:16];
                exp_second_next = 1'b1;
                state_next      = ST_EXP_MUL;
            end
            ST_SN_ND: begin
                if (den_calc[33] || (den_calc == 34'd0)) begin
                    c_next     = e_reg;
                    state_next = ST_DELTA1;
                end else begin
                    div_r_next     = '0;
                    div_q_next     = {num_calc[33] ? 33'd0 : num_calc[32:0], 16'd0};
                    div_v_next     = den_calc[32:0];
                    div_cnt_next   = 6'd48;
                    div_for_p_next = 1'b0;
                    state_next     = ST_DIV;
                end
            end
            ST_DELTA1: begin
                dx_next    = 32'(tlon_reg) - 32'(slon_reg) + DEG_180;
                state_next = ST_DELTA2;
            end
            ST_DELTA2: begin
                delta_next = wrap_fix(dx_reg);
                which_next = SEL_LON;
                state_next = ST_MQ_SETUP;
            end
            ST_MQ_SETUP: begin
                case (which_reg)
                    SEL_LON: begin
                        opv_next = delta_reg;
                        q_next   = c_reg;
                    end
                    SEL_LAT: begin
                        opv_next = tlat_c - 32'(slat_reg);
                        q_next   = c_reg;
                    end
                    default: begin
                        opv_next = 32'($signed({1'b0, tzoom_reg}))
                                 - 32'($signed({1'b0, szoom_reg}));
                        q_next   = e_reg;
                    end
                endcase
                state_next = ST_MQ_ABS;
            end
            ST_MQ_ABS: begin
                neg_next   = opv_reg[31];
                mag_next   = opv_reg[31] ? $unsigned(opv_neg) : $unsigned(opv_reg);
                state_next = ST_MQ_MUL;
            end
            ST_MQ_MUL: begin
                mul_a      = 34'(mag_reg);
                mul_b      = 32'(q_reg);
                state_next = ST_MQ_RND;
            end
            ST_MQ_RND: begin
                r_next     = $signed(rnd16[47:16]);
                state_next = ST_MQ_APPLY;
            end
            ST_MQ_APPLY: begin
                case (which_reg)
                    SEL_LON: begin
                        sum_next   = 32'(slon_reg) + DEG_180 + mq_term;
                        state_next = ST_LON_FIX;
                    end
                    SEL_LAT: begin
                        sum_next   = 32'(slat_reg) + mq_term;
                        state_next = ST_LAT_CLAMP;
                    end
                    default: begin
                        res_zoom_next = zsum[20:0];
                        state_next    = ST_OUT;
                    end
                endcase
            end
            ST_LON_FIX: begin
                res_lon_next = lon_fixed[28:0];
                which_next   = SEL_LAT;
                state_next   = res_fin_reg ? ST_OUT : ST_MQ_SETUP;
            end
            ST_LAT_CLAMP: begin
                res_lat_next = lat_fixed[27:0];
                which_next   = SEL_ZOOM;
                state_next   = ST_MQ_SETUP;
            end
            ST_FIN: begin
                sum_next      = 32'(tlon_reg) + DEG_180;
                res_lat_next  = tlat_c[27:0];
                res_zoom_next = tzoom_reg;
                running_next  = 1'b0;
                state_next    = ST_LON_FIX;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_upd_next   = res_upd_reg;
                    m_fin_next   = res_fin_reg;
                    m_lon_next   = res_lon_reg;
                    m_lat_next   = res_lat_reg;
                    m_zoom_next  = res_zoom_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT_LOAD;
            running_reg <= 1'b0;
            begin_reg   <= '0;
            kidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            running_reg <= running_next;
            begin_reg   <= begin_next;
            kidx_reg    <= kidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slon_reg  <= '0;
            slat_reg  <= '0;
            szoom_reg <= '0;
            tlon_reg  <= '0;
            tlat_reg  <= '0;
            tzoom_reg <= '0;
            dur_reg   <= '0;
            mode_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_START_LON:   slon_reg  <= $signed(cfg_wdata[28:0]);
                REG_START_LAT:   slat_reg  <= $signed(cfg_wdata[27:0]);
                REG_START_ZOOM:  szoom_reg <= cfg_wdata[20:0];
                REG_TARGET_LON:  tlon_reg  <= $signed(cfg_wdata[28:0]);
                REG_TARGET_LAT:  tlat_reg  <= $signed(cfg_wdata[27:0]);
                REG_TARGET_ZOOM: tzoom_reg <= cfg_wdata[20:0];
                REG_DURATION:    dur_reg   <= cfg_wdata;
                REG_CURVE_MODE:  mode_reg  <= cfg_wdata[1:0];
                default:         mode_reg  <= mode_reg;
            endcase
        end
    end

    // root ROM: entry i holds 2^(-2^-(i+1)) in Q32; read registered at k_next, so the entry for k_reg is ready for use
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_INIT_STEP) && (sq_cnt_reg == 5'd31)) begin
            krom_mem[kidx_reg] <= sq_root_next;
        end
        krom_rd_reg <= krom_mem[k_next];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        now_reg        <= now_next;
        sq_x_reg       <= sq_x_next;
        sq_rem_reg     <= sq_rem_next;
        sq_root_reg    <= sq_root_next;
        sq_cnt_reg     <= sq_cnt_next;
        el_reg         <= el_next;
        div_r_reg      <= div_r_next;
        div_q_reg      <= div_q_next;
        div_v_reg      <= div_v_next;
        div_cnt_reg    <= div_cnt_next;
        div_for_p_reg  <= div_for_p_next;
        p_reg          <= p_next;
        e_reg          <= e_next;
        c_reg          <= c_next;
        a_reg          <= a_next;
        dzneg_reg      <= dzneg_next;
        acc_reg        <= acc_next;
        k_reg          <= k_next;
        yint_reg       <= yint_next;
        yfrac_reg      <= yfrac_next;
        exp_second_reg <= exp_second_next;
        ea_reg         <= ea_next;
        eb_reg         <= eb_next;
        dx_reg         <= dx_next;
        delta_reg      <= delta_next;
        which_reg      <= which_next;
        opv_reg        <= opv_next;
        q_reg          <= q_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        r_reg          <= r_next;
        sum_reg        <= sum_next;
        res_upd_reg    <= res_upd_next;
        res_fin_reg    <= res_fin_next;
        res_lon_reg    <= res_lon_next;
        res_lat_reg    <= res_lat_next;
        res_zoom_reg   <= res_zoom_next;
        m_upd_reg      <= m_upd_next;
        m_fin_reg      <= m_fin_next;
        m_lon_reg      <= m_lon_next;
        m_lat_reg      <= m_lat_next;
        m_zoom_reg     <= m_zoom_next;
    end

    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation == OP_START)) |=> ##1 running_reg)
        else $error("start transfer did not arm the animation");

    a_finish_updates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> m_updated)
        else $error("finished result without update");

    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_updated) |->
            (m_out_lon == 29'sd0 && m_out_lat == 28'sd0 && m_out_zoom == 21'd0 && !m_finished))
        else $error("non-update result carries data");

    a_ease_below_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EASE1) |-> !p_reg[16])
        else $error("easing entered with full progress");

endmodule

`default_nettype wire
